/* rtl/core/gcds_pkg.sv */
// Shared constants, types and lookup tables for the gamma-aware 2x2 chroma downsampler.
package gcds_pkg;

	localparam int LINEAR_BITS     = 12;
	localparam int TABLE_FRAC_BITS = 7;
	localparam int LIN_SCALE       = (1 << LINEAR_BITS) - 1;
	localparam int POS_W           = LINEAR_BITS - TABLE_FRAC_BITS;
	localparam int GAM_ENTRIES     = (1 << POS_W) + 1;
	localparam int GAM_IDX_W       = POS_W + 1;
	localparam int STEP_BITS       = TABLE_FRAC_BITS + 2;
	localparam int STEP_ONE        = 1 << STEP_BITS;
	localparam int SUM_W           = LINEAR_BITS + 2;
	localparam int GAM_W           = 9;
	localparam int Y_W             = GAM_W + STEP_BITS + 1;
	localparam int AVG_W           = 10;
	localparam int SAMPLE_W        = 8;
	localparam int PIXEL_W         = 24;
	localparam int LANES           = 3;
	localparam int LIN_DEPTH       = 1 << SAMPLE_W;
	localparam int SEARCH_STEPS    = 32;

	typedef logic [LINEAR_BITS-1:0] lin_val_t;
	typedef lin_val_t lin_rom_t [LIN_DEPTH];
	typedef logic [GAM_W-1:0] gam_val_t;
	typedef gam_val_t gam_rom_t [GAM_ENTRIES];
	typedef logic [127:0] wide_t;

	typedef enum logic {
		REQ_FULL = 1'b0,
		REQ_LEFT = 1'b1
	} req_type_t;

	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_out;
	} gcds_adv_t;

	function automatic wide_t wide_pow_mul(wide_t a, int unsigned m, int unsigned times);
		wide_t r;
		r = a;
		for (int unsigned k = 0; k < times; k++) begin
			r = r * wide_t'(m);
		end
		return r;
	endfunction

	// True when the rounded value of S*(v/255)^0.8 is at least n.
	function automatic logic lin_ok(int unsigned n, int unsigned v);
		wide_t lhs;
		wide_t rhs;
		if (n == 0) begin
			return 1'b1;
		end
		lhs = wide_pow_mul(wide_pow_mul(wide_t'(1), 255, 4), 2 * n - 1, 5);
		rhs = wide_pow_mul(wide_pow_mul(wide_t'(32), LIN_SCALE, 5), v, 4);
		return (lhs <= rhs);
	endfunction

	// True when the rounded value of 255*(t*2^F/S)^1.25 is at least n.
	function automatic logic gam_ok(int unsigned n, int unsigned t);
		wide_t lhs;
		wide_t rhs;
		if (n == 0) begin
			return 1'b1;
		end
		lhs = wide_pow_mul(wide_pow_mul(wide_t'(1), LIN_SCALE, 5), 2 * n - 1, 4);
		rhs = wide_pow_mul(wide_pow_mul(wide_t'(16), 255, 4), t << TABLE_FRAC_BITS, 5);
		return (lhs <= rhs);
	endfunction

	function automatic lin_rom_t build_lin_rom();
		lin_rom_t    rom;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		for (int unsigned v = 0; v < LIN_DEPTH; v++) begin
			lo = 0;
			hi = LIN_SCALE;
			for (int it = 0; it < SEARCH_STEPS; it++) begin
				if (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					if (lin_ok(mid, v)) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
			end
			rom[v] = lin_val_t'(lo);
		end
		return rom;
	endfunction

	function automatic gam_rom_t build_gam_rom();
		gam_rom_t    rom;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		for (int unsigned t = 0; t < GAM_ENTRIES; t++) begin
			lo = 0;
			hi = (1 << GAM_W) - 1;
			for (int it = 0; it < SEARCH_STEPS; it++) begin
				if (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					if (gam_ok(mid, t)) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
			end
			rom[t] = gam_val_t'(lo);
		end
		return rom;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();
	localparam gam_rom_t GAM_ROM = build_gam_rom();

endpackage

/* rtl/core/gcds_ctrl.sv */
// Valid tracking and stage advance control for the downsampler pipeline.
module gcds_ctrl
	import gcds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	output logic      pix_stall,
	output logic      avg_valid,
	input  logic      avg_stall,
	output gcds_adv_t adv
);

	logic valid_s1;
	logic valid_s2;
	logic avg_valid_q;
	logic rdy_out;
	logic rdy_s2;
	logic rdy_s1;

	always_comb begin
		rdy_out     = !avg_valid_q || !avg_stall;
		rdy_s2      = !valid_s2 || rdy_out;
		rdy_s1      = !valid_s1 || rdy_s2;
		adv.adv_s1  = pix_valid && rdy_s1;
		adv.adv_s2  = valid_s1 && rdy_s2;
		adv.adv_out = valid_s2 && rdy_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			avg_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= pix_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_out) begin
				avg_valid_q <= valid_s2;
			end
		end
	end

	assign pix_stall = !rdy_s1;
	assign avg_valid = avg_valid_q;

endmodule

/* rtl/core/gcds_lane.sv */
// One color lane: linearizing lookups and sum, then interpolation in the gamma table.
module gcds_lane
	import gcds_pkg::*;
(
	input  logic                clk,
	input  gcds_adv_t           adv,
	input  logic                req_type,
	input  logic [SAMPLE_W-1:0] top_left,
	input  logic [SAMPLE_W-1:0] top_right,
	input  logic [SAMPLE_W-1:0] bottom_left,
	input  logic [SAMPLE_W-1:0] bottom_right,
	output logic [Y_W-1:0]      y_s2
);

	logic [SUM_W-1:0]     sum_d;
	logic [SUM_W-1:0]     sum_s1;
	logic [POS_W-1:0]     pos;
	logic [STEP_BITS-1:0] frac;
	logic [STEP_BITS:0]   w_hi;
	logic [STEP_BITS:0]   w_lo;
	gam_val_t             g_lo;
	gam_val_t             g_hi;
	logic [Y_W-1:0]       y_d;

	always_comb begin
		if (req_type == REQ_LEFT) begin
			sum_d = (SUM_W'(LIN_ROM[top_left]) + SUM_W'(LIN_ROM[bottom_left])) << 1;
		end else begin
			sum_d = SUM_W'(LIN_ROM[top_left]) + SUM_W'(LIN_ROM[top_right])
				+ SUM_W'(LIN_ROM[bottom_left]) + SUM_W'(LIN_ROM[bottom_right]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.adv_s1) begin
			sum_s1 <= sum_d;
		end
	end

	always_comb begin
		pos  = sum_s1[SUM_W-1 -: POS_W];
		frac = sum_s1[STEP_BITS-1:0];
		w_hi = {1'b0, frac};
		w_lo = (STEP_BITS+1)'(STEP_ONE) - w_hi;
		g_lo = GAM_ROM[{1'b0, pos}];
		g_hi = GAM_ROM[GAM_IDX_W'(pos) + GAM_IDX_W'(1)];
		y_d  = Y_W'(g_hi * w_hi) + Y_W'(g_lo * w_lo);
	end

	always_ff @(posedge clk) begin
		if (adv.adv_s2) begin
			y_s2 <= y_d;
		end
	end

endmodule

/* rtl/core/gcds_merge.sv */
// Output stage: rounds the three lane results and holds them for the output transaction.
module gcds_merge
	import gcds_pkg::*;
(
	input  logic             clk,
	input  gcds_adv_t        adv,
	input  logic [Y_W-1:0]   y_s2 [LANES],
	output logic [AVG_W-1:0] red_avg,
	output logic [AVG_W-1:0] green_avg,
	output logic [AVG_W-1:0] blue_avg
);

	logic [Y_W:0]       rounded [LANES];
	logic [AVG_W-1:0]   avg_q   [LANES];

	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			rounded[c] = {1'b0, y_s2[c]} + (Y_W+1)'(1 << (TABLE_FRAC_BITS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv.adv_out) begin
			for (int c = 0; c < LANES; c++) begin
				avg_q[c] <= rounded[c][TABLE_FRAC_BITS +: AVG_W];
			end
		end
	end

	assign red_avg   = avg_q[0];
	assign green_avg = avg_q[1];
	assign blue_avg  = avg_q[2];

endmodule

/* rtl/core/gamma_chroma_downsample_2x2.sv */
// Top level of the gamma-aware 2x2 chroma downsampler.
//
//   Transaction  Valid      Stall      Payload
//   pixels       pix_valid  pix_stall  req_type, top_left, top_right, bottom_left, bottom_right
//   averages     avg_valid  avg_stall  red_avg, green_avg, blue_avg
//
// One block enters per clock while pix_stall is low. Each block passes through
// the lookup-and-sum stage, the interpolation multiply stage and the rounding
// output register, with three color lanes working side by side.
// Reset clears only the stage valid flags; the tables are constants.
// A stall on the output fills the empty stages first and then reaches pix_stall.
module gamma_chroma_downsample_2x2
	import gcds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic               req_type,
	input  logic [PIXEL_W-1:0] top_left,
	input  logic [PIXEL_W-1:0] top_right,
	input  logic [PIXEL_W-1:0] bottom_left,
	input  logic [PIXEL_W-1:0] bottom_right,
	output logic               avg_valid,
	input  logic               avg_stall,
	output logic [AVG_W-1:0]   red_avg,
	output logic [AVG_W-1:0]   green_avg,
	output logic [AVG_W-1:0]   blue_avg
);

	gcds_adv_t      adv;
	logic [Y_W-1:0] y_s2 [LANES];

	gcds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall),
		.adv       (adv)
	);

	for (genvar c = 0; c < LANES; c++) begin : g_lane
		localparam int LSB = SAMPLE_W * (LANES - 1 - c);
		gcds_lane u_lane (
			.clk          (clk),
			.adv          (adv),
			.req_type     (req_type),
			.top_left     (top_left[LSB +: SAMPLE_W]),
			.top_right    (top_right[LSB +: SAMPLE_W]),
			.bottom_left  (bottom_left[LSB +: SAMPLE_W]),
			.bottom_right (bottom_right[LSB +: SAMPLE_W]),
			.y_s2         (y_s2[c])
		);
	end

	gcds_merge u_merge (
		.clk       (clk),
		.adv       (adv),
		.y_s2      (y_s2),
		.red_avg   (red_avg),
		.green_avg (green_avg),
		.blue_avg  (blue_avg)
	);

endmodule

/* rtl/core/gcds_chk.sv */
// Port-level checker for the downsampler, bound to the top level.
module gcds_chk
	import gcds_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               pix_valid,
	input logic               pix_stall,
	input logic               req_type,
	input logic [PIXEL_W-1:0] top_left,
	input logic [PIXEL_W-1:0] top_right,
	input logic [PIXEL_W-1:0] bottom_left,
	input logic [PIXEL_W-1:0] bottom_right,
	input logic               avg_valid,
	input logic               avg_stall,
	input logic [AVG_W-1:0]   red_avg,
	input logic [AVG_W-1:0]   green_avg,
	input logic [AVG_W-1:0]   blue_avg
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && avg_stall |=> avg_valid && $stable(red_avg) && $stable(green_avg)
			&& $stable(blue_avg))
		else $error("A stalled output transaction was dropped or changed.");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid |-> red_avg <= AVG_W'(1020) && green_avg <= AVG_W'(1020)
			&& blue_avg <= AVG_W'(1020))
		else $error("An average exceeds four times full scale.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall ##1 !avg_stall ##1 !avg_stall |=> avg_valid)
		else $error("An accepted transaction did not reach the output in three cycles.");

	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!avg_valid |-> !pix_stall)
		else $error("Input stalled although the output register is empty.");

endmodule

bind gamma_chroma_downsample_2x2 gcds_chk u_gcds_chk (.*);
